@@ sv/cfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame allocator package
// Field widths, command, status and map entry codes, and the sequencer
// states shared by the allocator files.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int unsigned FRAME_W   = 20;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned MAP_W     = 2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MARK    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INIT    = 2'd3;

   // Result status
   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOROOM  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTHEAD = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFREE = 3'd4;

   // Map entry codes
   localparam logic [MAP_W-1:0] MAP_FREE  = 2'd0;
   localparam logic [MAP_W-1:0] MAP_HEAD  = 2'd1;
   localparam logic [MAP_W-1:0] MAP_ALLOC = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE = 2'd2;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_ALLOC_SCAN,
      FSM_REL_HEAD,
      FSM_REL_WALK,
      FSM_MARK_CHECK,
      FSM_FILL,
      FSM_RESP
   } fsm_type;

endpackage

@@ sv/cfa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfa_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/contiguous_frame_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame allocator
// First-fit allocator over a per-frame state map held in a RAM, with
// allocate, release, mark-inaccessible and init commands.
// ----------------------------------------------------------------------------
// One command is worked at a time by a sequencer that visits one map entry
// per cycle through the single read and single write port of the map RAM.
// Allocate scans map entries up to the end of the first fitting run and then
// writes the run; an allocate that finds no room scans the whole pool.
// Release walks the run from its head, mark checks the whole range and then
// writes it, and init sweeps the whole map. Range errors and zero counts go
// straight to the result. The worst case is an allocate of the whole pool,
// which scans and then writes the whole pool. After reset the map is cleared
// by the same sweep, during which no item is accepted (configuration writes
// are still taken). The block is idle again once a result is loaded, so the
// next item can be accepted in the cycle after, while that result may still
// be waiting.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit #(
   parameter int unsigned MAP_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration
   input  logic                            csr_we,
   input  logic [cfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfa_pkg::FRAME_W-1:0]     csr_wdata,
   // Command channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cfa_pkg::CMD_W-1:0]       req_command,
   input  logic [cfa_pkg::FRAME_W-1:0]     req_frame_no,
   input  logic [cfa_pkg::COUNT_W-1:0]     req_count,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cfa_pkg::FRAME_W-1:0]     rsp_result_frame,
   output logic [cfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cfa_pkg::COUNT_W-1:0]     rsp_free_left
);

   import cfa_pkg::*;

   localparam int unsigned AW = $clog2(MAP_DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam logic [COUNT_W-1:0] FREE_RESET =
      COUNT_W'((MAP_DEPTH < 1024) ? MAP_DEPTH : 1024);
   localparam logic [CW-1:0] LAST_ENTRY = CW'(MAP_DEPTH - 1);
   localparam logic [31:0] FREE_MAX = 32'(2 ** COUNT_W - 1);

   // Configuration registers
   logic [FRAME_W-1:0] csr_base_ff;
   logic [COUNT_W-1:0] csr_pool_ff;
   logic               csr_reserve_ff;

   // Sequencer state
   fsm_type             state_ff, state_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       off_ff, off_in;
   logic [CW-1:0]       run_ff, run_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                mark_ff, mark_in;
   logic                init_cmd_ff, init_cmd_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FRAME_W-1:0]  res_frame_ff, res_frame_in;
   logic [COUNT_W-1:0]  free_total_ff, free_total_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   // Map RAM
   logic             map_wr_en;
   logic [AW-1:0]    map_wr_addr;
   logic [MAP_W-1:0] map_wr_data;
   logic [AW-1:0]    map_rd_addr;
   logic [MAP_W-1:0] map_rd_data;

   logic [31:0]        pool32;
   logic [31:0]        p32;
   logic [CW-1:0]      pool_size;
   logic [FRAME_W:0]   diff;
   logic               in_pool;
   logic               mark_fits;
   logic [CW-1:0]      run_next;
   logic [31:0]        head32;
   logic [31:0]        inc_sum;
   logic [COUNT_W-1:0] free_after_dec;
   logic               reserved;

   cfa_ram #(
      .WIDTH (MAP_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Effective pool size is the register clamped to the map depth.
   assign pool32    = 32'(csr_pool_ff);
   assign p32       = (pool32 > 32'(MAP_DEPTH)) ? 32'(MAP_DEPTH) : pool32;
   assign pool_size = p32[CW-1:0];

   assign diff      = {1'b0, req_frame_no} - {1'b0, csr_base_ff};
   assign in_pool   = !diff[FRAME_W] && (32'(diff[FRAME_W-1:0]) < p32);
   assign mark_fits = (32'(diff[FRAME_W-1:0]) + 32'(req_count)) <= p32;

   assign run_next  = (map_rd_data == MAP_FREE) ? (run_ff + CW'(1)) : '0;
   assign head32    = 32'(ptr_ff) + 32'd1 - 32'(cnt_ff);
   assign inc_sum   = 32'(free_total_ff) + 32'(run_ff);
   assign free_after_dec = (free_total_ff > cnt_ff) ? (free_total_ff - cnt_ff) : '0;
   assign reserved  = init_cmd_ff && csr_reserve_ff && (pool_size != '0);

   assign map_rd_addr = ptr_in[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      off_in        = off_ff;
      run_in        = run_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      mark_in       = mark_ff;
      init_cmd_in   = init_cmd_ff;
      status_in     = status_ff;
      res_frame_in  = res_frame_ff;
      free_total_in = free_total_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      map_wr_en     = 1'b0;
      map_wr_addr   = ptr_ff[AW-1:0];
      map_wr_data   = MAP_FREE;

      case (state_ff)
         FSM_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_data = (reserved && (ptr_ff == '0)) ? MAP_ALLOC : MAP_FREE;
            ptr_in      = ptr_ff + CW'(1);
            if (ptr_ff == LAST_ENTRY) begin
               if (init_cmd_ff) begin
                  free_total_in = COUNT_W'(p32) - COUNT_W'(reserved);
                  state_in      = FSM_RESP;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end

         FSM_IDLE: begin
            if (req_valid) begin
               status_in    = STAT_OK;
               res_frame_in = '0;
               cnt_in       = req_count;
               case (req_command)
                  CMD_ALLOC: begin
                     if (req_count == '0) begin
                        status_in = STAT_RANGE;
                        state_in  = FSM_RESP;
                     end else begin
                        ptr_in   = '0;
                        run_in   = '0;
                        mark_in  = 1'b0;
                        state_in = FSM_ALLOC_SCAN;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!in_pool) begin
                        status_in = STAT_RANGE;
                        state_in  = FSM_RESP;
                     end else begin
                        ptr_in   = diff[CW-1:0];
                        state_in = FSM_REL_HEAD;
                     end
                  end
                  CMD_MARK: begin
                     if (!in_pool || !mark_fits) begin
                        status_in = STAT_RANGE;
                        state_in  = FSM_RESP;
                     end else if (req_count == '0) begin
                        state_in = FSM_RESP;
                     end else begin
                        ptr_in   = diff[CW-1:0];
                        off_in   = diff[CW-1:0];
                        rem_in   = req_count;
                        mark_in  = 1'b1;
                        state_in = FSM_MARK_CHECK;
                     end
                  end
                  default: begin
                     ptr_in      = '0;
                     init_cmd_in = 1'b1;
                     state_in    = FSM_CLEAR;
                  end
               endcase
            end
         end

         FSM_ALLOC_SCAN: begin
            // Read data in this state belongs to the entry at ptr_ff.
            if (ptr_ff >= pool_size) begin
               status_in = STAT_NOROOM;
               state_in  = FSM_RESP;
            end else if (32'(run_next) == 32'(cnt_ff)) begin
               ptr_in   = head32[CW-1:0];
               off_in   = head32[CW-1:0];
               rem_in   = cnt_ff;
               state_in = FSM_FILL;
            end else begin
               run_in = run_next;
               ptr_in = ptr_ff + CW'(1);
            end
         end

         FSM_REL_HEAD: begin
            if (map_rd_data != MAP_HEAD) begin
               status_in = STAT_NOTHEAD;
               state_in  = FSM_RESP;
            end else begin
               map_wr_en = 1'b1;
               run_in    = CW'(1);
               ptr_in    = ptr_ff + CW'(1);
               state_in  = FSM_REL_WALK;
            end
         end

         FSM_REL_WALK: begin
            if ((ptr_ff >= pool_size) || (map_rd_data != MAP_ALLOC)) begin
               free_total_in = (inc_sum > FREE_MAX) ? COUNT_W'(FREE_MAX)
                                                    : inc_sum[COUNT_W-1:0];
               state_in      = FSM_RESP;
            end else begin
               map_wr_en = 1'b1;
               run_in    = run_ff + CW'(1);
               ptr_in    = ptr_ff + CW'(1);
            end
         end

         FSM_MARK_CHECK: begin
            // The whole range is checked before anything is written.
            if (map_rd_data != MAP_FREE) begin
               status_in = STAT_NOTFREE;
               state_in  = FSM_RESP;
            end else if (rem_ff == COUNT_W'(1)) begin
               ptr_in   = off_ff;
               rem_in   = cnt_ff;
               state_in = FSM_FILL;
            end else begin
               rem_in = rem_ff - COUNT_W'(1);
               ptr_in = ptr_ff + CW'(1);
            end
         end

         FSM_FILL: begin
            map_wr_en   = 1'b1;
            map_wr_data = (mark_ff || (ptr_ff == off_ff)) ? MAP_HEAD : MAP_ALLOC;
            if (rem_ff == COUNT_W'(1)) begin
               free_total_in = free_after_dec;
               if (!mark_ff) begin
                  res_frame_in = csr_base_ff + FRAME_W'(off_ff);
               end
               state_in = FSM_RESP;
            end else begin
               rem_in = rem_ff - COUNT_W'(1);
               ptr_in = ptr_ff + CW'(1);
            end
         end

         FSM_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = res_frame_ff;
               rsp_status_in = status_ff;
               rsp_free_in   = free_total_ff;
               init_cmd_in   = 1'b0;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_CLEAR;
         ptr_ff         <= '0;
         init_cmd_ff    <= 1'b0;
         free_total_ff  <= FREE_RESET;
         rsp_valid_ff   <= 1'b0;
         csr_base_ff    <= '0;
         csr_pool_ff    <= COUNT_W'(1024);
         csr_reserve_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         init_cmd_ff   <= init_cmd_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:    csr_base_ff    <= csr_wdata;
               CSR_POOL:    csr_pool_ff    <= csr_wdata[COUNT_W-1:0];
               CSR_RESERVE: csr_reserve_ff <= csr_wdata[0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      run_ff        <= run_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      mark_ff       <= mark_in;
      status_ff     <= status_in;
      res_frame_ff  <= res_frame_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_stall        = (state_ff != FSM_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_frame = rsp_frame_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_left    = rsp_free_ff;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame allocator testbench
// Drives allocate, release, mark and init items into the allocator under
// several pool settings and pacing patterns. A software copy of the frame
// map predicts every result, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   import cfa_pkg::*;

   localparam int unsigned DEPTH       = 1024;
   localparam int unsigned DRAIN_LIMIT = 200000;
   // Roughly one full map pass plus the longest run walk.
   localparam int unsigned TAIL_CYCLES = 2100;
   localparam int unsigned BASE_TOP    = 20'hFFFFF - 2100;

   typedef struct {
      logic [FRAME_W-1:0]  frame;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_left;
   } reply_type;

   typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   class frame_pool_model;
      logic [MAP_W-1:0] frame_state [DEPTH];
      int unsigned free_total;
      int unsigned base;
      int unsigned pool_frames;
      int unsigned reserve_first;
      reply_type   replies_due [$];
      int unsigned mismatch_count;

      function new();
         base           = 0;
         pool_frames    = DEPTH;
         reserve_first  = 0;
         mismatch_count = 0;
         foreach (frame_state[i]) frame_state[i] = MAP_FREE;
         free_total = pool_size();
      endfunction

      function int unsigned pool_size();
         return (pool_frames > DEPTH) ? DEPTH : pool_frames;
      endfunction

      function void take_frames(int unsigned n);
         free_total = (free_total > n) ? free_total - n : 0;
      endfunction

      function void give_frames(int unsigned n);
         free_total = (free_total + n > 2047) ? 2047 : free_total + n;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
         case (idx)
            CSR_BASE:    base = 32'(data);
            CSR_POOL:    pool_frames = 32'(data[COUNT_W-1:0]);
            CSR_RESERVE: reserve_first = 32'(data[0]);
            default: ;
         endcase
      endfunction

      // Works out the result of one accepted item and updates the map copy.
      function void note_command(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] fno,
                                 logic [COUNT_W-1:0] cnt);
         int unsigned p, f, c, off, run, last, n, i, h;
         bit found;
         reply_type r;
         p = pool_size();
         f = 32'(fno);
         c = 32'(cnt);
         r.frame = '0;
         r.status = STAT_OK;
         case (cmd)
            CMD_ALLOC: begin
               if (c == 0) begin
                  r.status = STAT_RANGE;
               end else begin
                  run = 0;
                  found = 0;
                  last = 0;
                  for (i = 0; i < p && !found; i++) begin
                     run = (frame_state[i] == MAP_FREE) ? run + 1 : 0;
                     if (run == c) begin
                        found = 1;
                        last = i;
                     end
                  end
                  if (found) begin
                     h = last + 1 - c;
                     frame_state[h] = MAP_HEAD;
                     for (i = h + 1; i <= last; i++) frame_state[i] = MAP_ALLOC;
                     take_frames(c);
                     r.frame = FRAME_W'(base + h);
                  end else begin
                     r.status = STAT_NOROOM;
                  end
               end
            end
            CMD_RELEASE: begin
               if (f < base || f - base >= p) begin
                  r.status = STAT_RANGE;
               end else begin
                  off = f - base;
                  if (frame_state[off] != MAP_HEAD) begin
                     r.status = STAT_NOTHEAD;
                  end else begin
                     frame_state[off] = MAP_FREE;
                     n = 1;
                     for (i = off + 1; i < p && frame_state[i] == MAP_ALLOC; i++) begin
                        frame_state[i] = MAP_FREE;
                        n++;
                     end
                     give_frames(n);
                  end
               end
            end
            CMD_MARK: begin
               if (f < base || f - base >= p || f - base + c > p) begin
                  r.status = STAT_RANGE;
               end else begin
                  off = f - base;
                  for (i = off; i < off + c; i++)
                     if (frame_state[i] != MAP_FREE) r.status = STAT_NOTFREE;
                  if (r.status == STAT_OK) begin
                     for (i = off; i < off + c; i++) frame_state[i] = MAP_HEAD;
                     take_frames(c);
                  end
               end
            end
            default: begin
               foreach (frame_state[k]) frame_state[k] = MAP_FREE;
               free_total = p;
               if (reserve_first != 0 && p > 0) begin
                  frame_state[0] = MAP_ALLOC;
                  take_frames(1);
               end
            end
         endcase
         r.free_left = COUNT_W'(free_total);
         replies_due.push_back(r);
      endfunction

      function void check_result(logic [FRAME_W-1:0] frame, logic [STATUS_W-1:0] status,
                                 logic [COUNT_W-1:0] free_left);
         reply_type want;
         if (replies_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with no item waiting: frame %h status %0d free %0d",
                        $realtime, frame, status, free_left);
         end else begin
            want = replies_due.pop_front();
            if (frame !== want.frame || status !== want.status ||
                free_left !== want.free_left) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: want frame %h status %0d free %0d, got %h %0d %0d",
                           $realtime, want.frame, want.status, want.free_left,
                           frame, status, free_left);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE;
   logic [FRAME_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command = CMD_ALLOC;
   logic [FRAME_W-1:0]   req_frame_no = '0;
   logic [COUNT_W-1:0]   req_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [FRAME_W-1:0]   rsp_result_frame;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_free_left;

   frame_pool_model pool_model;
   int unsigned send_pct = 0;
   int unsigned recv_pct = 0;
   int unsigned hold_left = 0;

   contiguous_frame_allocator_unit #(.MAP_DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_frame_no     (req_frame_no),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_frame (rsp_result_frame),
      .rsp_status       (rsp_status),
      .rsp_free_left    (rsp_free_left)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver either holds off for a counted stretch or stalls at random.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < recv_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            pool_model.check_result(rsp_result_frame, rsp_status, rsp_free_left);
         if (req_valid && !req_stall)
            pool_model.note_command(req_command, req_frame_no, req_count);
      end
   end

   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic set_pace(pace_type pace);
      case (pace)
         PACE_SENDER:   begin send_pct = 58; recv_pct = 0;  end
         PACE_RECEIVER: begin send_pct = 0;  recv_pct = 58; end
         PACE_BOTH:     begin send_pct = 9;  recv_pct = 9;  end
         default:       begin send_pct = 0;  recv_pct = 0;  end
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with the item still presented, so the caller must follow at once with
   // another item or with wait_idle.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] fno,
                               logic [COUNT_W-1:0] cnt);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command  = cmd;
      req_frame_no = fno;
      req_count    = cnt;
      req_valid    = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      req_valid = 1'b0;
      while (pool_model.replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      pool_model.set_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_pool(int unsigned base_v, int unsigned pool_v, bit reserve_v);
      wait_idle();
      write_reg(CSR_BASE, FRAME_W'(base_v));
      write_reg(CSR_POOL, FRAME_W'(pool_v));
      write_reg(CSR_RESERVE, FRAME_W'(reserve_v));
   endtask

   // Mostly well-formed items taken from the current map: small allocations,
   // releases of live heads and marks of short ranges, with noise mixed in.
   task automatic pick_command(output logic [CMD_W-1:0] cmd, output logic [FRAME_W-1:0] fno,
                               output logic [COUNT_W-1:0] cnt);
      int unsigned p, roll, off, k, span, pick;
      bit got;
      p = pool_model.pool_size();
      roll = $urandom_range(0, 99);
      fno = FRAME_W'($urandom);
      cnt = COUNT_W'($urandom);
      cmd = CMD_ALLOC;
      if (roll < 40) begin
         k = $urandom_range(0, 19);
         if (k == 0)
            cnt = '0;
         else if (k >= 8)
            cnt = COUNT_W'($urandom_range(1, (p >= 8) ? p / 4 : 2));
         else if (k >= 4)
            cnt = COUNT_W'($urandom_range(1, p + 1));
      end else if (roll < 70) begin
         cmd = CMD_RELEASE;
         got = 0;
         if (p > 0 && $urandom_range(0, 4) != 0) begin
            off = $urandom_range(0, p - 1);
            for (k = 0; k < p && !got; k++) begin
               pick = (off + k) % p;
               if (pool_model.frame_state[pick] == MAP_HEAD) begin
                  got = 1;
                  fno = FRAME_W'(pool_model.base + pick);
               end
            end
         end
         if (!got && $urandom_range(0, 1) == 1)
            fno = FRAME_W'(pool_model.base + $urandom_range(0, p + 2));
      end else if (roll < 90) begin
         cmd = CMD_MARK;
         if (p > 0 && $urandom_range(0, 3) != 0) begin
            off = $urandom_range(0, p - 1);
            span = p - off;
            fno = FRAME_W'(pool_model.base + off);
            cnt = COUNT_W'($urandom_range(0, (span < 4) ? span : 4));
         end
      end else if (roll < 93) begin
         cmd = CMD_INIT;
      end else begin
         cmd = CMD_W'($urandom);
      end
   endtask

   task automatic run_phase(pace_type pace, int unsigned base_v, int unsigned pool_v,
                            bit reserve_v, bit with_init, int unsigned items,
                            int unsigned hold);
      logic [CMD_W-1:0]   cmd;
      logic [FRAME_W-1:0] fno;
      logic [COUNT_W-1:0] cnt;
      write_pool(base_v, pool_v, reserve_v);
      set_pace(pace);
      if (with_init) send_command(CMD_INIT, FRAME_W'($urandom), COUNT_W'($urandom));
      hold_left = hold;
      repeat (items) begin
         pick_command(cmd, fno, cnt);
         send_command(cmd, fno, cnt);
      end
   endtask

   initial begin
      pool_model = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset state: base 0, full pool, nothing reserved.
      send_command(CMD_ALLOC,   20'd0,       11'd0);
      send_command(CMD_ALLOC,   20'd0,       11'd1);
      send_command(CMD_ALLOC,   20'd0,       11'h7FF);
      send_command(CMD_ALLOC,   20'd0,       11'd1024);
      send_command(CMD_ALLOC,   20'd0,       11'd1023);
      send_command(CMD_RELEASE, 20'd2,       11'd0);
      send_command(CMD_RELEASE, 20'd1,       11'd0);
      send_command(CMD_RELEASE, 20'hFFFFF,   11'h7FF);
      send_command(CMD_RELEASE, 20'd1024,    11'd0);
      send_command(CMD_RELEASE, 20'd0,       11'd0);
      send_command(CMD_MARK,    20'd10,      11'd5);
      send_command(CMD_MARK,    20'd12,      11'd1);
      send_command(CMD_MARK,    20'd1020,    11'd5);
      send_command(CMD_MARK,    20'd1019,    11'd5);
      send_command(CMD_MARK,    20'd5,       11'd0);
      send_command(CMD_MARK,    20'hFFFFF,   11'd1);
      send_command(CMD_RELEASE, 20'd12,      11'd0);
      send_command(CMD_ALLOC,   20'd0,       11'd3);
      send_command(CMD_INIT,    20'd0,       11'd0);

      // A pool at the top of the frame space with its first frame reserved,
      // so that the allocated head wraps round to frame zero.
      write_pool(20'hFFFFF, 8, 1'b1);
      send_command(CMD_INIT,    20'd0,       11'd0);
      send_command(CMD_ALLOC,   20'd0,       11'd7);
      send_command(CMD_RELEASE, 20'hFFFFF,   11'd0);
      send_command(CMD_MARK,    20'hFFFFF,   11'd0);

      write_pool(20'hFFFFF, 0, 1'b1);
      send_command(CMD_ALLOC,   20'd0,       11'd1);
      send_command(CMD_MARK,    20'hFFFFF,   11'd0);
      send_command(CMD_INIT,    20'd0,       11'd0);

      run_phase(PACE_FREE,     $urandom_range(0, BASE_TOP), 16,   1'b0, 1'b1, 90, 0);
      run_phase(PACE_SENDER,   $urandom_range(0, BASE_TOP), 48,   1'b1, 1'b1, 90, 0);
      run_phase(PACE_RECEIVER, $urandom_range(0, BASE_TOP), 2,    1'b0, 1'b1, 40, 0);
      run_phase(PACE_BOTH,     $urandom_range(0, BASE_TOP), 1024, 1'b1, 1'b1, 60, 0);
      // Pool shrunk without an init, while the receiver holds off long
      // enough for the block to fill up and stall its input.
      run_phase(PACE_FREE,     $urandom_range(0, BASE_TOP), 32,   1'b0, 1'b0, 60, 400);
      run_phase(PACE_SENDER,   0,                           2047, 1'b0, 1'b1, 40, 0);
      run_phase(PACE_RECEIVER, $urandom_range(0, BASE_TOP), 1,    1'b1, 1'b1, 30, 0);
      run_phase(PACE_BOTH,     $urandom_range(0, BASE_TOP), 200,  1'b0, 1'b0, 70, 0);
      run_phase(PACE_FREE,     $urandom_range(0, BASE_TOP), 0,    1'b0, 1'b0, 15, 0);
      run_phase(PACE_RECEIVER, 20'hFFFFF - 10,              24,   1'b1, 1'b1, 70, 0);

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pool_model.replies_due.size() != 0)
         $display("%0d results never arrived", pool_model.replies_due.size());
      if (pool_model.mismatch_count == 0 && pool_model.replies_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
